FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros shared by the ber element encoder rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property holds on every clock edge outside reset
`define BEE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("bee assertion failed");

// consequent holds in the same cycle as the antecedent
`define BEE_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("bee assertion failed");

// consequent holds in the cycle after the antecedent
`define BEE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("bee assertion failed");

`else

`define BEE_ASSERT(lbl, clk, rstn, prop)
`define BEE_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define BEE_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

FILE: src/bee_pkg.sv
// ----------------------------------------------------------------------------
// bee_pkg
// types and constants of the ber element encoder
// ----------------------------------------------------------------------------
package bee_pkg;

  localparam int RunMax        = 7;
  localparam int CntW          = 3;
  localparam int QueueDepthDef = 2;

  localparam logic [7:0] TagInteger = 8'h02;
  localparam logic [7:0] TagIpAddr  = 8'h40;
  localparam logic [7:0] TagOid     = 8'h06;
  localparam logic [7:0] TagOctStr  = 8'h04;
  localparam logic [7:0] LenLong2   = 8'h82;
  localparam logic [7:0] IpAddrLen  = 8'h04;

  typedef enum logic [2:0] {
    CMD_INT      = 3'd0,
    CMD_UINT     = 3'd1,
    CMD_IPV4     = 3'd2,
    CMD_OID_HDR  = 3'd3,
    CMD_OID_PAIR = 3'd4,
    CMD_OID_SUB  = 3'd5,
    CMD_SEQ_HDR  = 3'd6,
    CMD_STR_HDR  = 3'd7
  } cmd_e;

  // one command's octet run, first octet in entry 0
  typedef struct packed {
    logic [RunMax-1:0][7:0] bytes;
    logic [CntW-1:0]        cnt;
  } run_t;

endpackage

FILE: src/bee_cmd_if.sv
// ----------------------------------------------------------------------------
// bee_cmd_if
// command channel of the ber element encoder
// ----------------------------------------------------------------------------
interface bee_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [31:0] value;
  logic [7:0]  tag;
  logic [1:0]  first_arc;

  modport source (output valid, cmd, value, tag, first_arc, input ready);
  modport sink   (input valid, cmd, value, tag, first_arc, output ready);
endinterface

FILE: src/bee_byte_if.sv
// ----------------------------------------------------------------------------
// bee_byte_if
// encoded octet channel of the ber element encoder
// ----------------------------------------------------------------------------
interface bee_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, out_byte, last, input ready);
  modport sink   (input valid, out_byte, last, output ready);
endinterface

FILE: src/bee_front.sv
// ----------------------------------------------------------------------------
// bee_front
// accepts commands and builds the complete octet run of each
// ----------------------------------------------------------------------------
module bee_front (
  bee_cmd_if.sink          in_i,
  output logic             push_valid_o,
  input  logic             push_ready_i,
  output bee_pkg::run_t    push_data_o
);
  import bee_pkg::*;

  cmd_e        cmd;
  logic [34:0] b128_v;
  logic [34:0] b128_s;
  logic [2:0]  groups;
  logic [15:0] len_sat;
  logic [2:0]  ilen;
  logic [2:0]  ulen;
  logic [2:0]  clen;
  logic [31:0] be_s;
  logic [7:0]  hdr_tag;
  run_t        run;

  assign cmd          = cmd_e'(in_i.cmd);
  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid;
  assign push_data_o  = run;

  // first arc times forty as two shifts
  always_comb begin
    if (cmd == CMD_OID_PAIR) begin
      b128_v = (35'(in_i.first_arc) << 5) + (35'(in_i.first_arc) << 3)
             + 35'(in_i.value);
    end else begin
      b128_v = 35'(in_i.value);
    end
  end

  always_comb begin
    if (b128_v[34:28] != 7'd0) begin
      groups = 3'd5;
    end else if (b128_v[27:21] != 7'd0) begin
      groups = 3'd4;
    end else if (b128_v[20:14] != 7'd0) begin
      groups = 3'd3;
    end else if (b128_v[13:7] != 7'd0) begin
      groups = 3'd2;
    end else begin
      groups = 3'd1;
    end
  end

  // left-align the base-128 groups
  always_comb begin
    case (groups)
      3'd5:    b128_s = b128_v;
      3'd4:    b128_s = b128_v << 7;
      3'd3:    b128_s = b128_v << 14;
      3'd2:    b128_s = b128_v << 21;
      default: b128_s = b128_v << 28;
    endcase
  end

  assign len_sat = (|in_i.value[31:16]) ? 16'hFFFF : in_i.value[15:0];

  // minimal two's complement length
  always_comb begin
    if ((&in_i.value[31:7]) || !(|in_i.value[31:7])) begin
      ilen = 3'd1;
    end else if ((&in_i.value[31:15]) || !(|in_i.value[31:15])) begin
      ilen = 3'd2;
    end else if ((&in_i.value[31:23]) || !(|in_i.value[31:23])) begin
      ilen = 3'd3;
    end else begin
      ilen = 3'd4;
    end
  end

  always_comb begin
    if (!(|in_i.value[31:7])) begin
      ulen = 3'd1;
    end else if (!(|in_i.value[31:15])) begin
      ulen = 3'd2;
    end else if (!(|in_i.value[31:23])) begin
      ulen = 3'd3;
    end else if (!in_i.value[31]) begin
      ulen = 3'd4;
    end else begin
      ulen = 3'd5;
    end
  end

  assign clen = (cmd == CMD_INT) ? ilen : ulen;

  // left-align the content octets
  always_comb begin
    case (clen)
      3'd1:    be_s = in_i.value << 24;
      3'd2:    be_s = in_i.value << 16;
      3'd3:    be_s = in_i.value << 8;
      default: be_s = in_i.value;
    endcase
  end

  assign hdr_tag = (cmd == CMD_OID_HDR) ? TagOid : TagOctStr;

  always_comb begin
    run.bytes = '0;
    run.cnt   = '0;
    case (cmd)
      CMD_INT: begin
        run.bytes[0] = TagInteger;
        run.bytes[1] = 8'(ilen);
        for (int k = 0; k < 4; k++) begin
          run.bytes[2+k] = be_s[31-8*k -: 8];
        end
        run.cnt = ilen + 3'd2;
      end
      CMD_UINT: begin
        run.bytes[0] = in_i.tag;
        run.bytes[1] = 8'(ulen);
        if (ulen == 3'd5) begin
          run.bytes[2] = 8'h00;
          for (int k = 0; k < 4; k++) begin
            run.bytes[3+k] = in_i.value[31-8*k -: 8];
          end
        end else begin
          for (int k = 0; k < 4; k++) begin
            run.bytes[2+k] = be_s[31-8*k -: 8];
          end
        end
        run.cnt = ulen + 3'd2;
      end
      CMD_IPV4: begin
        run.bytes[0] = TagIpAddr;
        run.bytes[1] = IpAddrLen;
        for (int k = 0; k < 4; k++) begin
          run.bytes[2+k] = in_i.value[31-8*k -: 8];
        end
        run.cnt = 3'd6;
      end
      CMD_OID_HDR, CMD_STR_HDR: begin
        run.bytes[0] = hdr_tag;
        if (len_sat < 16'd128) begin
          run.bytes[1] = len_sat[7:0];
          run.cnt      = 3'd2;
        end else begin
          run.bytes[1] = LenLong2;
          run.bytes[2] = len_sat[15:8];
          run.bytes[3] = len_sat[7:0];
          run.cnt      = 3'd4;
        end
      end
      CMD_OID_PAIR, CMD_OID_SUB: begin
        for (int k = 0; k < 5; k++) begin
          run.bytes[k] = {(3'(k) + 3'd1 < groups), b128_s[34-7*k -: 7]};
        end
        run.cnt = groups;
      end
      CMD_SEQ_HDR: begin
        run.bytes[0] = in_i.tag;
        run.bytes[1] = LenLong2;
        run.bytes[2] = len_sat[15:8];
        run.bytes[3] = len_sat[7:0];
        run.cnt      = 3'd4;
      end
      default: begin
        run.bytes = '0;
        run.cnt   = '0;
      end
    endcase
  end

endmodule

FILE: src/bee_queue.sv
// ----------------------------------------------------------------------------
// bee_queue
// short run queue between front and back
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bee_queue #(
  parameter int Depth = bee_pkg::QueueDepthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  bee_pkg::run_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output bee_pkg::run_t pop_data_o
);
  import bee_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  run_t          mem_q [Depth];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          push;
  logic          pop;

  assign push_ready_o = (cnt_q != CW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `BEE_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CW'(Depth))
  `BEE_ASSERT_NEXT(a_cnt_inc, clk_i, rst_ni, push && !pop, cnt_q == $past(cnt_q) + CW'(1))

endmodule

FILE: src/bee_back.sv
// ----------------------------------------------------------------------------
// bee_back
// serialises queued runs into one octet per beat
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bee_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          run_valid_i,
  output logic          run_ready_o,
  input  bee_pkg::run_t run_i,
  bee_byte_if.source    out_o
);
  import bee_pkg::*;

  run_t            cur_q, cur_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic            busy_q, busy_d;
  logic            beat;
  logic            is_last;
  logic            load;

  assign beat        = busy_q && out_o.ready;
  assign is_last     = (idx_q == cur_q.cnt - CntW'(1));
  assign run_ready_o = !busy_q || (beat && is_last);
  assign load        = run_valid_i && run_ready_o;

  assign out_o.valid    = busy_q;
  assign out_o.out_byte = cur_q.bytes[idx_q];
  assign out_o.last     = is_last;

  always_comb begin
    cur_d  = cur_q;
    idx_d  = idx_q;
    busy_d = busy_q;
    if (load) begin
      cur_d  = run_i;
      idx_d  = '0;
      busy_d = 1'b1;
    end else if (beat) begin
      if (is_last) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      idx_q  <= idx_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  `BEE_ASSERT_IMPL(a_idx_in_run, clk_i, rst_ni, busy_q, idx_q < cur_q.cnt)
  `BEE_ASSERT_IMPL(a_run_nonempty, clk_i, rst_ni, busy_q, cur_q.cnt != '0)
  `BEE_ASSERT_NEXT(a_idle_after_last, clk_i, rst_ni, beat && is_last && !run_valid_i, !busy_q)

endmodule

FILE: src/ber_element_encoder.sv
// ----------------------------------------------------------------------------
// ber_element_encoder
// asn.1 ber element encoder: each command gives a run of octets, last flagged
//
//   port     dir   beat carries
//   cmd_i    in    cmd, value, tag, first_arc
//   byte_o   out   out_byte, last
//
// one octet leaves per cycle from the back serialiser while byte_o is ready;
// a command's run there holds one to seven octets
// the front builds a whole run in the cycle of acceptance and queues it
// commands are taken while the run queue has room, even while a run drains
// a stall on byte_o holds the current octet and fills the queue behind it
// reset clears the queue and the serialiser at once
// ----------------------------------------------------------------------------
module ber_element_encoder #(
  parameter int QueueDepth = bee_pkg::QueueDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bee_cmd_if.sink    cmd_i,
  bee_byte_if.source byte_o
);
  import bee_pkg::*;

  logic push_valid;
  logic push_ready;
  run_t push_data;
  logic pop_valid;
  logic pop_ready;
  run_t pop_data;

  bee_front u_front (
    .in_i         (cmd_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  bee_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  bee_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .run_valid_i (pop_valid),
    .run_ready_o (pop_ready),
    .run_i       (pop_data),
    .out_o       (byte_o)
  );

endmodule
